### src/dmareg_pkg.sv
// ----------------------------------------------------------------------------
// dmareg_pkg
// Shared types and constants of the disc DMA register block: item kinds,
// register addresses, stream widths and transfer timing.
// ----------------------------------------------------------------------------
`default_nettype none

package dmareg_pkg;

    // Field widths
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned TICK_W   = 40;
    localparam int unsigned PROT_W   = 16;
    localparam int unsigned TIMING_N = 8;
    localparam int unsigned TIMING_IDX_W = $clog2(TIMING_N);

    // Stream widths: fields packed from bit 0, padded to whole bytes
    localparam int unsigned S_FIELDS_W = ADDR_W + DATA_W + 1;
    localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_FIELDS_W = DATA_W + 1 + 1 + ADDR_W + DATA_W + 1;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Transfer timing
    localparam int unsigned TICKS_PER_BYTE = 32;

    // Protection key sits in the upper half of the write data
    localparam logic [PROT_W-1:0] PROT_KEY = 16'h8843;
    localparam logic [DATA_W-1:0] PROT_STATUS_OK = 32'd3;

    // Register addresses
    localparam logic [ADDR_W-1:0] ADDR_START    = 32'h005F_7404;
    localparam logic [ADDR_W-1:0] ADDR_LENGTH   = 32'h005F_7408;
    localparam logic [ADDR_W-1:0] ADDR_DIR      = 32'h005F_740C;
    localparam logic [ADDR_W-1:0] ADDR_ENABLE   = 32'h005F_7414;
    localparam logic [ADDR_W-1:0] ADDR_RUN      = 32'h005F_7418;
    localparam logic [ADDR_W-1:0] ADDR_TIMING0  = 32'h005F_7480;
    localparam logic [ADDR_W-1:0] ADDR_TIMING1  = 32'h005F_7484;
    localparam logic [ADDR_W-1:0] ADDR_TIMING2  = 32'h005F_7488;
    localparam logic [ADDR_W-1:0] ADDR_TIMING3  = 32'h005F_748C;
    localparam logic [ADDR_W-1:0] ADDR_TIMING4  = 32'h005F_7490;
    localparam logic [ADDR_W-1:0] ADDR_TIMING5  = 32'h005F_7494;
    localparam logic [ADDR_W-1:0] ADDR_TIMING6  = 32'h005F_74A0;
    localparam logic [ADDR_W-1:0] ADDR_TIMING7  = 32'h005F_74A4;
    localparam logic [ADDR_W-1:0] ADDR_IO_READY = 32'h005F_74B4;
    localparam logic [ADDR_W-1:0] ADDR_PROTECT  = 32'h005F_74B8;
    localparam logic [ADDR_W-1:0] ADDR_ROM_PROT = 32'h005F_74E4;
    localparam logic [ADDR_W-1:0] ADDR_PROT_STS = 32'h005F_74EC;
    localparam logic [ADDR_W-1:0] ADDR_DBG_ADDR = 32'h005F_74F4;
    localparam logic [ADDR_W-1:0] ADDR_DBG_LEN  = 32'h005F_74F8;

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_READ32     = 3'd0,
        KIND_READ_OTHER = 3'd1,
        KIND_WRITE16    = 3'd2,
        KIND_WRITE32    = 3'd3,
        KIND_WRITE_OTH  = 3'd4,
        KIND_SET_READY  = 3'd5,
        KIND_RETRY      = 3'd6,
        KIND_TICK       = 3'd7
    } kind_t;

endpackage : dmareg_pkg

`default_nettype wire

### src/disc_dma_register_block_top.sv
// ----------------------------------------------------------------------------
// disc_dma_register_block_top
// Bus-side register block of a disc DMA port: decodes register accesses,
// launches transfers and counts them down on tick requests.
// ----------------------------------------------------------------------------
// Path: an accepted request enters the input register; after one pass of
//   decode and update its result is captured in the result register.
// Throughput: one request per cycle; a held result stalls the input only
//   once the input register is also full.
// Reset: rst_n asynchronous, active low; clears both valid flags, the
//   architectural registers and the transfer countdown.
`default_nettype none

module disc_dma_register_block_top
    import dmareg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Request channel
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // tdata: address[31:0], write_data[63:32], ready_level[64], zero pad
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // tuser: kind[2:0]
    input  wire logic [KIND_W-1:0]    s_axis_tuser,
    // Result channel
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // tdata: read_data[31:0], fault[32], launch[33], launch_address[65:34],
    //        launch_length[97:66], done_interrupt[98], zero pad
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    // Input register
    logic              in_valid_reg;
    kind_t             in_kind_reg;
    logic [ADDR_W-1:0] in_addr_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              in_level_reg;

    // Result register
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_read_data_reg;
    logic              out_fault_reg;
    logic              out_launch_reg;
    logic [ADDR_W-1:0] out_launch_addr_reg;
    logic [DATA_W-1:0] out_launch_len_reg;
    logic              out_done_reg;

    // Architectural registers
    logic [ADDR_W-1:0] start_address_reg,   start_address_next;
    logic [DATA_W-1:0] transfer_length_reg, transfer_length_next;
    logic              direction_flag_reg,  direction_flag_next;
    logic              enable_flag_reg,     enable_flag_next;
    logic              running_flag_reg,    running_flag_next;
    logic              drive_ready_reg,     drive_ready_next;
    logic [ADDR_W-1:0] debug_address_reg,   debug_address_next;
    logic [DATA_W-1:0] debug_length_reg,    debug_length_next;
    logic [DATA_W-1:0] timing_words_reg  [TIMING_N];
    logic [DATA_W-1:0] timing_words_next [TIMING_N];
    logic              io_ready_enable_reg, io_ready_enable_next;
    logic [PROT_W-1:0] protect_window_reg,  protect_window_next;
    logic [DATA_W-1:0] rom_protect_reg,     rom_protect_next;
    logic [TICK_W-1:0] ticks_left_reg,      ticks_left_next;
    logic              pending_reg,         pending_next;

    // Per-request results
    logic [DATA_W-1:0] read_data_c;
    logic              fault_c;
    logic              launch_c;
    logic              done_c;
    logic              launch_try_c;
    logic              running_try_c;
    logic [TICK_W-1:0] ticks_dec_c;
    logic [TICK_W-1:0] ticks_load_c;

    logic              advance;
    logic              do_step;

    // Handshake: the input stage moves whenever the result slot is free
    assign advance       = !out_valid_reg || m_axis_tready;
    assign do_step       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;

    assign ticks_load_c = TICK_W'(transfer_length_reg) * TICK_W'(TICKS_PER_BYTE);
    assign ticks_dec_c  = (ticks_left_reg != '0) ? (ticks_left_reg - TICK_W'(1))
                                                 : ticks_left_reg;

    // Decode the request and work out the next register values
    always_comb
    begin
        start_address_next   = start_address_reg;
        transfer_length_next = transfer_length_reg;
        direction_flag_next  = direction_flag_reg;
        enable_flag_next     = enable_flag_reg;
        running_flag_next    = running_flag_reg;
        drive_ready_next     = drive_ready_reg;
        debug_address_next   = debug_address_reg;
        debug_length_next    = debug_length_reg;
        timing_words_next    = timing_words_reg;
        io_ready_enable_next = io_ready_enable_reg;
        protect_window_next  = protect_window_reg;
        rom_protect_next     = rom_protect_reg;
        ticks_left_next      = ticks_left_reg;
        pending_next         = pending_reg;

        read_data_c   = '0;
        fault_c       = 1'b0;
        done_c        = 1'b0;
        launch_try_c  = 1'b0;
        running_try_c = running_flag_reg;

        unique case (in_kind_reg)
            KIND_READ32:
            begin
                unique case (in_addr_reg)
                    ADDR_ENABLE:   read_data_c = DATA_W'(enable_flag_reg);
                    ADDR_RUN:      read_data_c = DATA_W'(running_flag_reg);
                    ADDR_PROT_STS: read_data_c = PROT_STATUS_OK;
                    ADDR_DBG_ADDR: read_data_c = debug_address_reg;
                    ADDR_DBG_LEN:  read_data_c = debug_length_reg;
                    default:       read_data_c = '0;
                endcase
            end
            KIND_WRITE16:
            begin
                if (in_addr_reg == ADDR_TIMING0)
                    timing_words_next[0] = DATA_W'(in_data_reg[PROT_W-1:0]);
                else
                    fault_c = 1'b1;
            end
            KIND_WRITE32:
            begin
                unique case (in_addr_reg)
                    ADDR_START:    start_address_next   = in_data_reg;
                    ADDR_LENGTH:   transfer_length_next = in_data_reg;
                    ADDR_DIR:      direction_flag_next  = in_data_reg[0];
                    ADDR_ENABLE:   enable_flag_next     = in_data_reg[0];
                    ADDR_RUN:
                    begin
                        running_flag_next = in_data_reg[0];
                        running_try_c     = in_data_reg[0];
                        launch_try_c      = in_data_reg[0];
                    end
                    ADDR_TIMING1:  timing_words_next[1] = in_data_reg;
                    ADDR_TIMING2:  timing_words_next[2] = in_data_reg;
                    ADDR_TIMING3:  timing_words_next[3] = in_data_reg;
                    ADDR_TIMING4:  timing_words_next[4] = in_data_reg;
                    ADDR_TIMING5:  timing_words_next[5] = in_data_reg;
                    ADDR_TIMING6:  timing_words_next[6] = in_data_reg;
                    ADDR_TIMING7:  timing_words_next[7] = in_data_reg;
                    ADDR_IO_READY: io_ready_enable_next = in_data_reg[0];
                    ADDR_PROTECT:
                    begin
                        // Accept the window only under the key
                        if (in_data_reg[DATA_W-1:PROT_W] == PROT_KEY)
                            protect_window_next = in_data_reg[PROT_W-1:0];
                    end
                    ADDR_ROM_PROT: rom_protect_next = in_data_reg;
                    default:       fault_c = 1'b1;
                endcase
            end
            KIND_SET_READY:
            begin
                drive_ready_next = in_level_reg;
            end
            KIND_RETRY:
            begin
                launch_try_c = 1'b1;
            end
            KIND_TICK:
            begin
                // Count down and complete the transfer at zero
                if (pending_reg)
                begin
                    ticks_left_next = ticks_dec_c;
                    if (ticks_dec_c == '0)
                    begin
                        pending_next       = 1'b0;
                        running_flag_next  = 1'b0;
                        done_c             = 1'b1;
                        debug_address_next = start_address_reg + transfer_length_reg;
                        debug_length_next  = transfer_length_reg;
                    end
                end
            end
            KIND_READ_OTHER, KIND_WRITE_OTH:
            begin
                fault_c = 1'b1;
            end
            default:
            begin
                fault_c = 1'b1;
            end
        endcase

        // Launch when the run bit is set and the drive is ready
        launch_c = launch_try_c && running_try_c && drive_ready_reg;
        if (launch_c)
        begin
            debug_address_next = start_address_reg;
            debug_length_next  = '0;
            ticks_left_next    = ticks_load_c;
            pending_next       = 1'b1;
        end
    end

    // Input register: hold the request until the pass has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg  <= kind_t'(s_axis_tuser);
            in_addr_reg  <= s_axis_tdata[ADDR_W-1:0];
            in_data_reg  <= s_axis_tdata[ADDR_W +: DATA_W];
            in_level_reg <= s_axis_tdata[ADDR_W + DATA_W];
        end
    end

    // Result register: advance when the slot is empty or the consumer takes the current result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_step)
        begin
            out_read_data_reg   <= read_data_c;
            out_fault_reg       <= fault_c;
            out_launch_reg      <= launch_c;
            out_launch_addr_reg <= launch_c ? start_address_reg : '0;
            out_launch_len_reg  <= launch_c ? transfer_length_reg : '0;
            out_done_reg        <= done_c;
        end
    end

    assign m_axis_tdata = M_TDATA_W'({out_done_reg, out_launch_len_reg, out_launch_addr_reg,
                                      out_launch_reg, out_fault_reg, out_read_data_reg});

    // Register file: update once per processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg   <= '0;
            transfer_length_reg <= '0;
            direction_flag_reg  <= 1'b0;
            enable_flag_reg     <= 1'b0;
            running_flag_reg    <= 1'b0;
            drive_ready_reg     <= 1'b0;
            debug_address_reg   <= '0;
            debug_length_reg    <= '0;
            for (int i = 0; i < TIMING_N; i++)
            begin
                timing_words_reg[i] <= '0;
            end
            io_ready_enable_reg <= 1'b0;
            protect_window_reg  <= '0;
            rom_protect_reg     <= '0;
            ticks_left_reg      <= '0;
            pending_reg         <= 1'b0;
        end
        else if (do_step)
        begin
            start_address_reg   <= start_address_next;
            transfer_length_reg <= transfer_length_next;
            direction_flag_reg  <= direction_flag_next;
            enable_flag_reg     <= enable_flag_next;
            running_flag_reg    <= running_flag_next;
            drive_ready_reg     <= drive_ready_next;
            debug_address_reg   <= debug_address_next;
            debug_length_reg    <= debug_length_next;
            timing_words_reg    <= timing_words_next;
            io_ready_enable_reg <= io_ready_enable_next;
            protect_window_reg  <= protect_window_next;
            rom_protect_reg     <= rom_protect_next;
            ticks_left_reg      <= ticks_left_next;
            pending_reg         <= pending_next;
        end
    end

endmodule : disc_dma_register_block_top

`default_nettype wire
